@@ rtl/tssw_pkg.sv @@
// Shared constants, types and helpers for the triangle span walker
`default_nettype none
package tssw_pkg;

	// default fixed-point layout
	localparam int COORD_FRAC_BITS_DEF = 8;
	localparam int SLOPE_FRAC_BITS_DEF = 16;

	// field widths
	localparam int VW    = 19;
	localparam int ROW_W = 11;
	localparam int XS_W  = 11;
	localparam int XE_W  = 12;
	localparam int ACC_W = 32;

	// which slope the divider is working on
	typedef enum logic [1:0] {
		SEL_LONG,
		SEL_TOP,
		SEL_BOT
	} div_sel_t;

	// controller to datapath
	typedef struct packed {
		logic     load;
		logic     step;
		logic     div_start;
		div_sel_t div_sel;
		logic     finish;
		logic     busy;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic div_done;
		logic out_full;
	} dp_status_t;

	// saturate a wide signed value to 32 bits
	function automatic logic signed [ACC_W-1:0] sat32(input logic signed [63:0] v);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = 64'sh0000_0000_7FFF_FFFF;
		lo = -64'sh0000_0000_8000_0000;
		if (v > hi)
			return ACC_W'(hi);
		else if (v < lo)
			return ACC_W'(lo);
		else
			return ACC_W'(v);
	endfunction

	// saturating 32-bit add
	function automatic logic signed [ACC_W-1:0] sat_add32(input logic signed [ACC_W-1:0] a,
			input logic signed [ACC_W-1:0] b);
		logic signed [63:0] s;
		s = 64'(a) + 64'(b);
		return sat32(s);
	endfunction

endpackage
`default_nettype wire

@@ rtl/tssw_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle
`default_nettype none
module tssw_div #(
	parameter int NUMW = 35,
	parameter int DENW = 19
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic [NUMW-1:0] num,
	input  wire logic [DENW-1:0] den,
	output logic                 done,
	output logic [NUMW-1:0]      quo
);
	localparam int CW = $clog2(NUMW + 1);

	logic [DENW-1:0] rem_q;
	logic [NUMW-1:0] quo_q;
	logic [CW-1:0]   cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [DENW:0]   trial;
	logic            qbit;

	// trial subtract of the shifted remainder
	always_comb begin
		trial = {rem_q, quo_q[NUMW-1]};
		qbit  = (trial >= {1'b0, den});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NUMW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= qbit ? DENW'(trial - {1'b0, den}) : DENW'(trial);
			quo_q <= {quo_q[NUMW-2:0], qbit};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule
`default_nettype wire

@@ rtl/tssw_datapath.sv @@
// Datapath: vertex sort, slope set-up, edge accumulators and span output register
`default_nettype none
module tssw_datapath #(
	parameter int COORD_FRAC_BITS = tssw_pkg::COORD_FRAC_BITS_DEF,
	parameter int SLOPE_FRAC_BITS = tssw_pkg::SLOPE_FRAC_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire tssw_pkg::ctrl_cmd_t           cmd,
	output tssw_pkg::dp_status_t               status,
	input  wire logic signed [tssw_pkg::VW-1:0] ax,
	input  wire logic signed [tssw_pkg::VW-1:0] ay,
	input  wire logic signed [tssw_pkg::VW-1:0] bx,
	input  wire logic signed [tssw_pkg::VW-1:0] by_coord,
	input  wire logic signed [tssw_pkg::VW-1:0] cx,
	input  wire logic signed [tssw_pkg::VW-1:0] cy,
	input  wire logic                          out_ready,
	output logic                               out_valid,
	output logic signed [tssw_pkg::ROW_W-1:0]  row,
	output logic signed [tssw_pkg::XS_W-1:0]   x_start,
	output logic signed [tssw_pkg::XE_W-1:0]   x_stop,
	output logic                               last_span
);
	localparam int VW    = tssw_pkg::VW;
	localparam int DW    = VW + 1;
	localparam int AW    = tssw_pkg::ACC_W;
	localparam int NUMW  = VW + SLOPE_FRAC_BITS;
	localparam int ROWW  = VW + 1 - COORD_FRAC_BITS;
	localparam logic signed [DW-1:0] CUNIT = DW'(1) <<< COORD_FRAC_BITS;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_TOP,
		PH_BOT
	} phase_t;

	// vertex x into accumulator format, truncated toward zero, saturated
	function automatic logic signed [AW-1:0] to_acc(input logic signed [VW-1:0] x);
		logic signed [63:0] t;
		t = 64'(x) <<< SLOPE_FRAC_BITS;
		if (t < 0)
			t = t + ((64'sd1 <<< COORD_FRAC_BITS) - 64'sd1);
		t = t >>> COORD_FRAC_BITS;
		return tssw_pkg::sat32(t);
	endfunction

	// y to integer row, truncated toward zero
	function automatic logic signed [ROWW-1:0] to_row(input logic signed [VW-1:0] y);
		logic signed [DW-1:0] t;
		t = DW'(y);
		if (t < 0)
			t = t + (CUNIT - DW'(1));
		t = t >>> COORD_FRAC_BITS;
		return ROWW'(t);
	endfunction

	// sorted vertices: t = top (min y), m = middle, b = bottom (max y)
	logic signed [VW-1:0] xt_q, yt_q, xm_q, ym_q, xb_q, yb_q;
	logic signed [AW-1:0] long_slope_q, slope_top_q, slope_bot_q;
	logic signed [AW-1:0] edge_acc_q, long_acc_q;
	logic signed [ROWW-1:0] row_q;
	logic [1:0]           long_left_q;
	phase_t               phase_q;

	localparam int ROW_W_L = tssw_pkg::ROW_W;
	logic signed [ROW_W_L-1:0] row_out_q;
	logic signed [tssw_pkg::XS_W-1:0] xs_q;
	logic signed [tssw_pkg::XE_W-1:0] xe_q;
	logic                 last_q;
	logic                 out_valid_q;

	// y ordering with the max-first tie rule
	logic signed [VW-1:0] vx [3];
	logic signed [VW-1:0] vy [3];
	logic [1:0]           mx, mn, md;

	always_comb begin
		vx[0] = ax; vy[0] = ay;
		vx[1] = bx; vy[1] = by_coord;
		vx[2] = cx; vy[2] = cy;
		mx = 2'd0;
		mn = 2'd0;
		for (int i = 1; i < 3; i++) begin
			if (vy[i] >= vy[mx])
				mx = 2'(i);
			else if (vy[i] <= vy[mn])
				mn = 2'(i);
		end
		md = 2'(2'd3 - mn - mx);
	end

	// divider operands for the selected edge
	logic signed [DW-1:0] dx, dy;
	logic                 neg;
	logic [VW-1:0]        mag;
	logic [NUMW-1:0]      num;
	logic                 div_done;
	logic [NUMW-1:0]      quo;
	logic                 zero_slope;
	logic signed [AW-1:0] slope_res;
	logic [63:0]          q64;

	always_comb begin
		case (cmd.div_sel)
			tssw_pkg::SEL_TOP: begin
				dx = DW'(xm_q) - DW'(xt_q);
				dy = DW'(ym_q) - DW'(yt_q);
			end
			tssw_pkg::SEL_BOT: begin
				dx = DW'(xb_q) - DW'(xm_q);
				dy = DW'(yb_q) - DW'(ym_q);
			end
			default: begin
				dx = DW'(xb_q) - DW'(xt_q);
				dy = DW'(yb_q) - DW'(yt_q);
			end
		endcase
		neg = dx[DW-1];
		mag = neg ? VW'(-dx) : VW'(dx);
		num = {mag, {SLOPE_FRAC_BITS{1'b0}}};
		zero_slope = (cmd.div_sel == tssw_pkg::SEL_LONG) ? (dy <= 0) : (dy < CUNIT);
		// sign and saturate the magnitude quotient
		q64 = 64'(quo);
		if (zero_slope)
			slope_res = '0;
		else if (!neg)
			slope_res = (q64 > 64'h7FFF_FFFF) ? AW'(64'h7FFF_FFFF) : AW'(q64);
		else
			slope_res = (q64 > 64'h8000_0000) ? AW'(64'h8000_0000) : AW'(-q64);
	end

	tssw_div #(
		.NUMW(NUMW),
		.DENW(VW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (num),
		.den   (dy[VW-1:0]),
		.done  (div_done),
		.quo   (quo)
	);

	// per-span edge reads and advance
	logic                 long_left;
	logic signed [AW-1:0] left, right;
	logic signed [AW:0]   lt, rt;
	logic signed [AW:0]   xs_w, xe_w;
	logic signed [tssw_pkg::XS_W-1:0] xs_c;
	logic signed [tssw_pkg::XE_W-1:0] xe_c;
	logic signed [ROWW-1:0] next_row;
	logic signed [31:0]   next_y;
	logic                 top_on, bot_on;

	always_comb begin
		long_left = (phase_q == PH_TOP) ? long_left_q[0] : long_left_q[1];
		left  = long_left ? long_acc_q : edge_acc_q;
		right = long_left ? edge_acc_q : long_acc_q;
		lt = (AW+1)'(left);
		if (lt < 0)
			lt = lt + (((AW+1)'(1) <<< SLOPE_FRAC_BITS) - (AW+1)'(1));
		xs_w = lt >>> SLOPE_FRAC_BITS;
		rt = (AW+1)'(right) + (((AW+1)'(1) <<< SLOPE_FRAC_BITS) - (AW+1)'(1));
		xe_w = rt >>> SLOPE_FRAC_BITS;
		if (xs_w < -(AW+1)'(1024))
			xs_c = -tssw_pkg::XS_W'(1024);
		else if (xs_w > (AW+1)'(1023))
			xs_c = tssw_pkg::XS_W'(1023);
		else
			xs_c = tssw_pkg::XS_W'(xs_w);
		if (xe_w < -(AW+1)'(1024))
			xe_c = -tssw_pkg::XE_W'(1024);
		else if (xe_w > (AW+1)'(1024))
			xe_c = tssw_pkg::XE_W'(1024);
		else
			xe_c = tssw_pkg::XE_W'(xe_w);
		next_row = row_q + ROWW'(1);
		next_y   = 32'(next_row) <<< COORD_FRAC_BITS;
		top_on   = (DW'(ym_q) - DW'(yt_q)) >= CUNIT;
		bot_on   = (DW'(yb_q) - DW'(ym_q)) >= CUNIT;
	end

	// sorted vertex capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			xt_q <= vx[mn]; yt_q <= vy[mn];
			xm_q <= vx[md]; ym_q <= vy[md];
			xb_q <= vx[mx]; yb_q <= vy[mx];
		end
	end

	// triangle walk state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			row_q        <= '0;
			edge_acc_q   <= '0;
			long_acc_q   <= '0;
			long_slope_q <= '0;
			slope_top_q  <= '0;
			slope_bot_q  <= '0;
			long_left_q  <= '0;
		end else begin
			if (div_done) begin
				case (cmd.div_sel)
					tssw_pkg::SEL_TOP:  slope_top_q  <= slope_res;
					tssw_pkg::SEL_BOT:  slope_bot_q  <= slope_res;
					default:            long_slope_q <= slope_res;
				endcase
			end
			if (cmd.finish) begin
				long_left_q <= {!(slope_bot_q > long_slope_q), !(slope_top_q < long_slope_q)};
				long_acc_q  <= to_acc(xt_q);
				if (top_on) begin
					phase_q    <= PH_TOP;
					row_q      <= to_row(yt_q);
					edge_acc_q <= to_acc(xt_q);
				end else if (bot_on) begin
					phase_q    <= PH_BOT;
					row_q      <= to_row(ym_q);
					edge_acc_q <= to_acc(xm_q);
				end else begin
					phase_q    <= PH_IDLE;
					row_q      <= '0;
					edge_acc_q <= '0;
				end
			end else if (cmd.step && (phase_q == PH_TOP || phase_q == PH_BOT)) begin
				long_acc_q <= tssw_pkg::sat_add32(long_acc_q, long_slope_q);
				if (phase_q == PH_TOP) begin
					edge_acc_q <= tssw_pkg::sat_add32(edge_acc_q, slope_top_q);
					if (next_y >= 32'(ym_q)) begin
						if (bot_on) begin
							phase_q    <= PH_BOT;
							row_q      <= to_row(ym_q);
							edge_acc_q <= to_acc(xm_q);
						end else begin
							phase_q <= PH_IDLE;
						end
					end else begin
						row_q <= next_row;
					end
				end else begin
					edge_acc_q <= tssw_pkg::sat_add32(edge_acc_q, slope_bot_q);
					if (next_y >= 32'(yb_q))
						phase_q <= PH_IDLE;
					else
						row_q <= next_row;
				end
			end
		end
	end

	// span output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.step && (phase_q == PH_TOP || phase_q == PH_BOT)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step && (phase_q == PH_TOP || phase_q == PH_BOT)) begin
			row_out_q <= ROW_W_L'(row_q);
			xs_q      <= xs_c;
			xe_q      <= xe_c;
			if (phase_q == PH_TOP)
				last_q <= (next_y >= 32'(ym_q)) && !bot_on;
			else
				last_q <= (next_y >= 32'(yb_q));
		end
	end

	assign status.div_done = div_done;
	assign status.out_full = out_valid_q;
	assign out_valid = out_valid_q;
	assign row       = row_out_q;
	assign x_start   = xs_q;
	assign x_stop    = xe_q;
	assign last_span = last_q;
endmodule
`default_nettype wire

@@ rtl/tssw_ctrl.sv @@
// Controller: input handshake and the sequence of slope divisions after a load
`default_nettype none
module tssw_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	input  wire logic                 mode,
	input  wire logic                 out_ready,
	input  wire tssw_pkg::dp_status_t status,
	output logic                      in_ready,
	output tssw_pkg::ctrl_cmd_t       cmd
);
	typedef enum logic [1:0] {
		C_IDLE,
		C_DIV,
		C_FIN
	} state_t;

	state_t              state_q;
	logic                start_q;
	tssw_pkg::div_sel_t  sel_q;
	logic                accept;

	// new transaction only when idle and the span register can take a result
	assign in_ready = (state_q == C_IDLE) && (!status.out_full || out_ready);
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			start_q <= 1'b0;
			sel_q   <= tssw_pkg::SEL_LONG;
		end else begin
			start_q <= 1'b0;
			case (state_q)
				C_IDLE: begin
					if (accept && !mode) begin
						state_q <= C_DIV;
						start_q <= 1'b1;
						sel_q   <= tssw_pkg::SEL_LONG;
					end
				end
				C_DIV: begin
					if (status.div_done) begin
						case (sel_q)
							tssw_pkg::SEL_LONG: begin
								sel_q   <= tssw_pkg::SEL_TOP;
								start_q <= 1'b1;
							end
							tssw_pkg::SEL_TOP: begin
								sel_q   <= tssw_pkg::SEL_BOT;
								start_q <= 1'b1;
							end
							default: state_q <= C_FIN;
						endcase
					end
				end
				C_FIN:   state_q <= C_IDLE;
				default: state_q <= C_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd.load      = accept && !mode;
		cmd.step      = accept && mode;
		cmd.div_start = start_q;
		cmd.div_sel   = sel_q;
		cmd.finish    = (state_q == C_FIN);
		cmd.busy      = (state_q == C_DIV);
	end
endmodule
`default_nettype wire

@@ rtl/triangle_scanline_span_walker.sv @@
// Top level of the scanline triangle span walker
// Usage:
//  Input channel (in_valid/in_ready): mode 0 loads a triangle from ax..cy
//  (signed fixed point), mode 1 asks for the next span. A load replaces any
//  triangle still being walked; a step with no triangle active gives nothing.
//  Output channel (out_valid/out_ready): one span per step transaction,
//  row, x_start, x_stop (pixels x_start <= x < x_stop) and last_span.
// Timing:
//  A load keeps in_ready low from its acceptance until the one-bit-per-cycle
//  divider, shared by the long, top and bottom slopes, has worked through each
//  in turn and the finish state is done. A step's span appears in the output
//  register in the next cycle, so spans stream at one per cycle while the sink
//  keeps out_ready high. When the sink stalls, one span waits in the output
//  register and in_ready drops until it is taken; no span is lost or repeated.
// Reset: arst_n clears the controller and walk state; no triangle is active
//  and the output register is empty.
`default_nettype none
module triangle_scanline_span_walker #(
	parameter int COORD_FRAC_BITS = tssw_pkg::COORD_FRAC_BITS_DEF,
	parameter int SLOPE_FRAC_BITS = tssw_pkg::SLOPE_FRAC_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic                           mode,
	input  wire logic signed [tssw_pkg::VW-1:0] ax,
	input  wire logic signed [tssw_pkg::VW-1:0] ay,
	input  wire logic signed [tssw_pkg::VW-1:0] bx,
	input  wire logic signed [tssw_pkg::VW-1:0] by_coord,
	input  wire logic signed [tssw_pkg::VW-1:0] cx,
	input  wire logic signed [tssw_pkg::VW-1:0] cy,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic signed [tssw_pkg::ROW_W-1:0]   row,
	output logic signed [tssw_pkg::XS_W-1:0]    x_start,
	output logic signed [tssw_pkg::XE_W-1:0]    x_stop,
	output logic                                last_span
);
	tssw_pkg::ctrl_cmd_t  cmd;
	tssw_pkg::dp_status_t status;

	tssw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.mode     (mode),
		.out_ready(out_ready),
		.status   (status),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	tssw_datapath #(
		.COORD_FRAC_BITS(COORD_FRAC_BITS),
		.SLOPE_FRAC_BITS(SLOPE_FRAC_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.ax       (ax),
		.ay       (ay),
		.bx       (bx),
		.by_coord (by_coord),
		.cx       (cx),
		.cy       (cy),
		.out_ready(out_ready),
		.out_valid(out_valid),
		.row      (row),
		.x_start  (x_start),
		.x_stop   (x_stop),
		.last_span(last_span)
	);

	// a load transaction always starts the slope divisions
	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !mode |=> !in_ready && cmd.div_start)
		else $error("load did not start the divider");

	// divider results only arrive while the controller waits for them
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		status.div_done |-> cmd.busy)
		else $error("divider result outside a division");

	// never take a transaction that could overwrite a waiting span
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !(out_valid && !out_ready))
		else $error("input ready while a span is stalled");
endmodule
`default_nettype wire
